/* design/gf2qse_pkg.sv */
// ----------------------------------------------------------------------------
// gf2qse_pkg
// Shared constants and types for the GF(2) quadratic system evaluator.
// ----------------------------------------------------------------------------
package gf2qse_pkg;

  // Default sizing of the coefficient store
  localparam int MAX_VARS_DEF = 16;
  localparam int EQ_WIDTH_DEF = 32;

  // Stream field widths
  localparam int OP_W      = 1;
  localparam int INDEX_W   = 8;
  localparam int COEF_W    = 32;
  localparam int ASSIGN_W  = 16;
  localparam int RESULT_W  = 32;
  localparam int IN_DATA_W = 56;  // index + coef + assignment, padded to bytes

  // Configuration register
  localparam int NUM_VARS_W = 5;
  localparam logic [NUM_VARS_W-1:0] NUM_VARS_RESET = 5'd16;

  // Item kinds carried in tuser
  typedef enum logic [OP_W-1:0] {
    OpWrite = 1'b0,
    OpEval  = 1'b1
  } op_e;

endpackage

/* design/gf2qse_ram.sv */
// ----------------------------------------------------------------------------
// gf2qse_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gf2qse_ram #(
  parameter int Width = 32,
  parameter int Depth = 137
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write one word, read one word per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/gf2_quadratic_system_eval_unit.sv */
// Operation: a write gives no result and may follow back to back; an evaluate walks
//   W = 1 + n + n*(n-1)/2 coefficient words (137 at n = 16) and hands its result to the
//   output register once a held result there is taken; no new item is accepted until then.
//   The walk feeds one RAM word per cycle into the XOR fold.
// Reset: rst_ni clears the sequencer and output valid and sets num_vars to 16;
//   the coefficient RAM is not cleared and must be written before it is read.
// ----------------------------------------------------------------------------
// gf2_quadratic_system_eval_unit
// Bitsliced GF(2) quadratic system evaluator: stores coefficient words and
// XORs the words whose monomial is one under a given variable assignment.
// ----------------------------------------------------------------------------
module gf2_quadratic_system_eval_unit #(
  parameter int MaxVars = gf2qse_pkg::MAX_VARS_DEF,
  parameter int EqWidth = gf2qse_pkg::EQ_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [7:0] coef_index, [39:8] coef_value, [55:40] assignment
  input  logic [gf2qse_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // [0] operation
  input  logic [gf2qse_pkg::OP_W-1:0]         s_axis_tuser,
  // Result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [31:0] equation_values
  output logic [gf2qse_pkg::RESULT_W-1:0]     m_axis_tdata,
  // Configuration write channel: num_vars
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [gf2qse_pkg::NUM_VARS_W-1:0]   cfg_data_i
);

  import gf2qse_pkg::*;

  localparam int StoreDepth = 1 + MaxVars + (MaxVars * (MaxVars - 1)) / 2;
  localparam int AddrW      = $clog2(StoreDepth);
  localparam int IdxW       = $clog2(MaxVars);
  localparam int VarW       = $clog2(MaxVars + 1);

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StConst = 5'b00010,
    StLin   = 5'b00100,
    StQuad  = 5'b01000,
    StDone  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [NUM_VARS_W-1:0] num_vars_q;
  logic [VarW-1:0]       n_eff;
  logic [VarW-1:0]       n_q, n_d;
  logic [MaxVars-1:0]    assign_q, assign_d;
  logic [IdxW-1:0]       vi_q, vi_d;
  logic [IdxW-1:0]       vj_q, vj_d;
  logic [AddrW-1:0]      addr_q, addr_d;
  logic                  pend_q, pend_d;
  logic                  mono_q, mono_d;
  logic [EqWidth-1:0]    acc_q, acc_d, acc_next;
  logic                  out_valid_q, out_valid_d;
  logic [RESULT_W-1:0]   out_data_q, out_data_d;

  logic [INDEX_W-1:0]    in_index;
  logic [COEF_W-1:0]     in_coef;
  logic [ASSIGN_W-1:0]   in_assign;
  logic [MaxVars-1:0]    in_assign_ext;
  logic                  in_xfer;
  logic                  wr_en;
  logic [EqWidth-1:0]    rdata;
  logic [VarW-1:0]       vi_p1, vi_p2, vj_p1;

  // Unpack the input item
  assign in_index  = s_axis_tdata[7:0];
  assign in_coef   = s_axis_tdata[39:8];
  assign in_assign = s_axis_tdata[55:40];
  assign in_xfer   = s_axis_tvalid && s_axis_tready;

  // Widen or trim the assignment to the variable count
  always_comb begin
    for (int k = 0; k < MaxVars; k++) begin
      in_assign_ext[k] = (k < ASSIGN_W) ? in_assign[k % ASSIGN_W] : 1'b0;
    end
  end

  // Clamp the configured variable count
  assign n_eff = (int'(num_vars_q) > MaxVars) ? VarW'(MaxVars) : VarW'(num_vars_q);

  // Configuration register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_vars_q <= NUM_VARS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      num_vars_q <= cfg_data_i;
    end
  end

  // Coefficient store
  assign wr_en = in_xfer && (op_e'(s_axis_tuser) == OpWrite)
                 && (int'(in_index) < StoreDepth);

  gf2qse_ram #(
    .Width(EqWidth),
    .Depth(StoreDepth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(AddrW'(in_index)),
    .wdata_i(EqWidth'(in_coef)),
    .raddr_i(addr_q),
    .rdata_o(rdata)
  );

  // Fold in the word read on the previous cycle
  assign acc_next = (pend_q && mono_q) ? (acc_q ^ rdata) : acc_q;

  assign vi_p1 = VarW'(vi_q) + VarW'(1);
  assign vi_p2 = VarW'(vi_q) + VarW'(2);
  assign vj_p1 = VarW'(vj_q) + VarW'(1);

  // Sequencer: walk constant, linear and product words in store order
  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    assign_d    = assign_q;
    vi_d        = vi_q;
    vj_d        = vj_q;
    addr_d      = addr_q;
    pend_d      = 1'b0;
    mono_d      = 1'b0;
    acc_d       = acc_next;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (m_axis_tvalid && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_xfer && (op_e'(s_axis_tuser) == OpEval)) begin
          n_d      = n_eff;
          assign_d = in_assign_ext;
          addr_d   = '0;
          acc_d    = '0;
          state_d  = StConst;
        end
      end
      StConst: begin
        pend_d = 1'b1;
        mono_d = 1'b1;
        addr_d = addr_q + AddrW'(1);
        vi_d   = '0;
        state_d = (n_q == '0) ? StDone : StLin;
      end
      StLin: begin
        pend_d = 1'b1;
        mono_d = assign_q[vi_q];
        addr_d = addr_q + AddrW'(1);
        if (vi_p1 == n_q) begin
          if (n_q == VarW'(1)) begin
            state_d = StDone;
          end else begin
            vi_d    = '0;
            vj_d    = IdxW'(1);
            state_d = StQuad;
          end
        end else begin
          vi_d = IdxW'(vi_p1);
        end
      end
      StQuad: begin
        pend_d = 1'b1;
        mono_d = assign_q[vi_q] & assign_q[vj_q];
        addr_d = addr_q + AddrW'(1);
        if (vj_p1 == n_q) begin
          if (vi_p2 == n_q) begin
            state_d = StDone;
          end else begin
            vi_d = IdxW'(vi_p1);
            vj_d = IdxW'(vi_p2);
          end
        end else begin
          vj_d = IdxW'(vj_p1);
        end
      end
      StDone: begin
        // Hand over once the output register is free
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = RESULT_W'(acc_next);
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    assign_q   <= assign_d;
    vi_q       <= vi_d;
    vj_q       <= vj_d;
    addr_q     <= addr_d;
    mono_q     <= mono_d;
    acc_q      <= acc_d;
    out_data_q <= out_data_d;
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

/* design/gf2qse_checker.sv */
// ----------------------------------------------------------------------------
// gf2qse_checker
// Port-level checks for the GF(2) quadratic system evaluator.
// ----------------------------------------------------------------------------
module gf2qse_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [gf2qse_pkg::OP_W-1:0]      s_axis_tuser,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [gf2qse_pkg::RESULT_W-1:0]  m_axis_tdata
);

  import gf2qse_pkg::*;

  logic in_xfer;
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or dropped");

  // Go busy after an evaluate transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (op_e'(s_axis_tuser) == OpEval) |=> !s_axis_tready)
    else $error("input still ready after evaluate transfer");

  // Stay ready after a write transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (op_e'(s_axis_tuser) == OpWrite) |=> s_axis_tready)
    else $error("write transfer left input not ready");

  // Raise a result only at the end of an evaluation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result raised while sequencer idle");

endmodule

bind gf2_quadratic_system_eval_unit gf2qse_checker u_gf2qse_checker (.*);

/* test/gf2_quadratic_system_eval_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf2_quadratic_system_eval_unit_tb
// Self-checking bench for the GF(2) quadratic system evaluator. It loads
// every coefficient word, runs directed evaluations at the corners of the
// variable count and the assignment, and then sends random write/evaluate
// traffic over several num_vars settings. It checks each result against an
// in-bench shadow of the coefficient store, with random stalls on both streams.
// ----------------------------------------------------------------------------
module gf2_quadratic_system_eval_unit_tb;
  import gf2qse_pkg::*;

  localparam int StoreDepth  = 1 + MAX_VARS_DEF + (MAX_VARS_DEF * (MAX_VARS_DEF - 1)) / 2;
  localparam int CfgSettle   = 8;
  localparam int EndSettle   = StoreDepth + 16;
  localparam int CycleLimit  = 1_000_000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [OP_W-1:0]       s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [RESULT_W-1:0]   m_axis_tdata;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [NUM_VARS_W-1:0] cfg_data_i = '0;

  // Shadow of the block state
  logic [COEF_W-1:0]     coef_shadow [StoreDepth];
  logic [NUM_VARS_W-1:0] num_vars_shadow;
  logic [RESULT_W-1:0]   pending_equations [$];
  logic [RESULT_W-1:0]   want_equations;

  int send_idle_pct;
  int recv_stall_pct;
  int err_count;
  int n_writes;
  int n_evals;
  int n_results;
  int n_cfg;
  int cycle_count;

  gf2_quadratic_system_eval_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("gf2_quadratic_system_eval_unit_tb NOT OK");
      $finish;
    end
  end

  // Stall the result stream at random
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check each result transfer against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_equations.size() == 0) begin
        err_count++;
        $error("equation_values: expected none, actual %08h", m_axis_tdata);
      end else begin
        want_equations = pending_equations.pop_front();
        n_results++;
        if (m_axis_tdata !== want_equations) begin
          err_count++;
          $error("equation_values: expected %08h, actual %08h", want_equations, m_axis_tdata);
        end
      end
    end
  end

  // Number of coefficient words read at a given variable count
  function automatic int layout_words(input int nv);
    int n;
    n = (nv > MAX_VARS_DEF) ? MAX_VARS_DEF : nv;
    return 1 + n + (n * (n - 1)) / 2;
  endfunction

  // XOR the constant word with every word whose monomial is one
  function automatic logic [RESULT_W-1:0] predict_equations(input logic [ASSIGN_W-1:0] asg);
    int n;
    int pos;
    logic [RESULT_W-1:0] acc;
    n = (num_vars_shadow > MAX_VARS_DEF) ? MAX_VARS_DEF : int'(num_vars_shadow);
    acc = coef_shadow[0];
    for (int i = 0; i < n; i++) begin
      if (asg[i]) acc ^= coef_shadow[1 + i];
    end
    pos = n + 1;
    for (int i = 0; i < n; i++) begin
      for (int j = i + 1; j < n; j++) begin
        if (asg[i] && asg[j]) acc ^= coef_shadow[pos];
        pos++;
      end
    end
    return acc;
  endfunction

  // Send one item, then update the shadow on its transfer
  task automatic send_item(input op_e op, input logic [INDEX_W-1:0] idx,
                           input logic [COEF_W-1:0] val, input logic [ASSIGN_W-1:0] asg);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {asg, val, idx};
    do begin
      @(negedge clk_i);
      taken = s_axis_tready;
      @(posedge clk_i);
    end while (!taken);
    if (op == OpWrite) begin
      n_writes++;
      if (idx < StoreDepth) coef_shadow[idx] = val;
    end else begin
      n_evals++;
      pending_equations.push_back(predict_equations(asg));
    end
  endtask

  // Drop valid, wait for every result, then let the block go quiet
  task automatic settle_idle(input int extra);
    s_axis_tvalid <= 1'b0;
    while (pending_equations.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  // Write num_vars while the block is idle
  task automatic write_num_vars(input logic [NUM_VARS_W-1:0] nv);
    bit taken;
    settle_idle(CfgSettle);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= nv;
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
    cfg_valid_i <= 1'b0;
    num_vars_shadow = nv;
    n_cfg++;
  endtask

  // Load every store entry so no evaluation reads an unwritten word
  task automatic test_fill_store();
    send_item(OpWrite, 8'd0, 32'hFFFF_FFFF, 16'h0000);
    for (int i = 1; i < StoreDepth; i++) begin
      send_item(OpWrite, INDEX_W'(i), $urandom(), 16'(~i));
    end
  endtask

  // Corners of the assignment, the index and the variable count
  task automatic test_directed_evals();
    write_num_vars(5'd16);
    send_item(OpEval, 8'd0, 32'h0, 16'h0000);
    send_item(OpEval, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(OpEval, 8'd0, 32'h0, 16'h0001);
    send_item(OpEval, 8'd0, 32'h0, 16'h8000);
    // last product word, x14*x15
    send_item(OpWrite, 8'd136, 32'hA5A5_5A5A, 16'h0000);
    send_item(OpEval, 8'd0, 32'h0, 16'hC000);
    // out-of-range writes are dropped
    send_item(OpWrite, 8'd137, 32'hFFFF_FFFF, 16'h0000);
    send_item(OpWrite, 8'd255, 32'h1234_5678, 16'hFFFF);
    send_item(OpEval, 8'd0, 32'h0, 16'hFFFF);
    // one variable: upper assignment bits ignored, word 100 unused
    write_num_vars(5'd1);
    send_item(OpEval, 8'd0, 32'h0, 16'hFFFE);
    send_item(OpEval, 8'd0, 32'h0, 16'hFFFF);
    send_item(OpWrite, 8'd100, 32'hDEAD_BEEF, 16'h0000);
    send_item(OpEval, 8'd0, 32'h0, 16'hFFFF);
    // zero variables: constant word alone
    write_num_vars(5'd0);
    send_item(OpEval, 8'd0, 32'h0, 16'hFFFF);
    send_item(OpWrite, 8'd0, 32'h0000_0000, 16'h0000);
    send_item(OpEval, 8'd0, 32'h0, 16'h0000);
    // above the maximum: clamped to sixteen
    write_num_vars(5'd31);
    send_item(OpEval, 8'd0, 32'h0, 16'hFFFF);
    send_item(OpEval, 8'd0, 32'h0, 16'h5A5A);
  endtask

  // Random writes and evaluations, num_vars changed every segment
  task automatic test_random_traffic(input int items, input int seg);
    int nv;
    for (int k = 0; k < items; k++) begin
      if (k % seg == 0) begin
        case ($urandom_range(9))
          0:       nv = 0;
          1:       nv = $urandom_range(31, 17);
          2, 3:    nv = 16;
          default: nv = $urandom_range(8, 1);
        endcase
        write_num_vars(NUM_VARS_W'(nv));
      end
      if ($urandom_range(9) < 4) begin
        send_item(OpWrite,
                  ($urandom_range(9) == 0) ? INDEX_W'($urandom_range(255))
                                           : INDEX_W'($urandom_range(layout_words(nv) - 1)),
                  $urandom(), 16'($urandom()));
      end else begin
        send_item(OpEval, INDEX_W'($urandom()), $urandom(), 16'($urandom()));
      end
    end
  endtask

  initial begin
    send_idle_pct   = 18;
    recv_stall_pct  = 83;
    num_vars_shadow = NUM_VARS_RESET;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_fill_store();
    test_directed_evals();
    test_random_traffic(115, 40);

    send_idle_pct  = 83;
    recv_stall_pct = 18;
    test_random_traffic(115, 40);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_traffic(115, 40);

    settle_idle(EndSettle);
    $display("covered %0d coefficient writes and %0d evaluations, %0d results checked",
             n_writes, n_evals, n_results);
    $display("num_vars written %0d times, with 0, 1, 16 and values above 16", n_cfg);
    if (err_count == 0) begin
      $display("gf2_quadratic_system_eval_unit_tb OK");
    end else begin
      $display("gf2_quadratic_system_eval_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

/* sim.f */
design/gf2qse_pkg.sv
design/gf2qse_ram.sv
design/gf2_quadratic_system_eval_unit.sv
design/gf2qse_checker.sv
test/gf2_quadratic_system_eval_unit_tb.sv
